/* rtl/core/e2q_pkg.sv */
// e2q_pkg: constants and types for the euler angle to quaternion pipeline
// no dependencies

package e2q_pkg;

    localparam int ANGLE_WIDTH_DEF = 16;
    localparam int TRIG_STAGES_DEF = 16;
    localparam int MAX_STAGES      = 32;

    localparam logic [32:0] PHASE_MUL = 33'd5468522205;
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
    localparam logic signed [17:0] Q14_ONE = 18'sd16384;

    typedef logic signed [33:0] t_cval;

    function automatic t_cval atan_lookup(input int idx);
        logic [31:0] v;
        begin
            unique case (idx)
                0: v = 32'd536870912;  1: v = 32'd316933406;
                2: v = 32'd167458907;  3: v = 32'd85004756;
                4: v = 32'd42667331;   5: v = 32'd21354465;
                6: v = 32'd10679838;   7: v = 32'd5340245;
                8: v = 32'd2670163;    9: v = 32'd1335087;
                10: v = 32'd667544;    11: v = 32'd333772;
                12: v = 32'd166886;    13: v = 32'd83443;
                14: v = 32'd41721;     15: v = 32'd20860;
                16: v = 32'd10430;     17: v = 32'd5215;
                18: v = 32'd2607;      19: v = 32'd1303;
                20: v = 32'd651;       21: v = 32'd325;
                22: v = 32'd162;       23: v = 32'd81;
                24: v = 32'd40;        25: v = 32'd20;
                26: v = 32'd10;        27: v = 32'd5;
                28: v = 32'd2;         29: v = 32'd1;
                default: v = 32'd0;
            endcase
            atan_lookup = t_cval'({2'b00, v});
        end
    endfunction

endpackage

/* rtl/core/e2q_trig.sv */
// e2q_trig: half-angle phase, quadrant split and pipelined cordic for one angle
// depends on e2q_pkg; stalls through the shared enable i_en

module e2q_trig #(
    parameter int ANGLE_WIDTH = e2q_pkg::ANGLE_WIDTH_DEF,
    parameter int TRIG_STAGES = e2q_pkg::TRIG_STAGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [ANGLE_WIDTH-1:0] i_angle,
    output logic signed [17:0]            o_cos,
    output logic signed [17:0]            o_sin
);
    import e2q_pkg::*;

    localparam int NS = (TRIG_STAGES < MAX_STAGES) ? TRIG_STAGES : MAX_STAGES;
    // at least 48 bits so the phase slice always exists
    localparam int PW = (ANGLE_WIDTH + 33 > 48) ? ANGLE_WIDTH + 33 : 48;

    // stage 0: phase multiply
    logic signed [PW-1:0] r_prod;
    logic [31:0]          w_phase;
    logic [31:0]          w_resid;
    logic [1:0]           w_quad;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PW'(i_angle) * $signed({1'b0, PHASE_MUL});
        end
    end

    assign w_phase = r_prod[47:16];
    assign w_quad  = 2'((w_phase + 32'h2000_0000) >> 30);
    assign w_resid = w_phase - {w_quad, 30'd0};

    t_cval      r_x [NS+1];
    t_cval      r_y [NS+1];
    t_cval      r_z [NS+1];
    logic [1:0] r_q [NS+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CORDIC_X0;
            r_y[0] <= '0;
            r_z[0] <= t_cval'($signed(w_resid));
            r_q[0] <= w_quad;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][33]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_lookup(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_lookup(i);
                end
                r_q[i+1] <= r_q[i];
            end
        end
    end

    // quadrant fix and rounding to q16
    t_cval n_c, n_s;
    always_comb begin
        unique case (r_q[NS])
            2'd0: begin n_c = r_x[NS];  n_s = r_y[NS];  end
            2'd1: begin n_c = -r_y[NS]; n_s = r_x[NS];  end
            2'd2: begin n_c = -r_x[NS]; n_s = -r_y[NS]; end
            default: begin n_c = r_y[NS]; n_s = -r_x[NS]; end
        endcase
    end

    t_cval w_cr, w_sr;
    assign w_cr = (n_c + t_cval'(8192)) >>> 14;
    assign w_sr = (n_s + t_cval'(8192)) >>> 14;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= w_cr[17:0];
            o_sin <= w_sr[17:0];
        end
    end

endmodule

/* rtl/core/euler_to_quaternion.sv */
// euler_to_quaternion: top level, zyx euler angles to a unit quaternion
// depends on e2q_pkg and e2q_trig

// Converts roll, pitch and yaw (signed Q3.12 radians, sign-extended from
// bit ANGLE_WIDTH-1) into the quaternion w, x, y, z in signed Q1.14,
// saturated to plus or minus one. One transaction is taken every cycle
// while the output is not stalled. The registers in order: phase multiply,
// cordic load, one register per cordic stage (TRIG_STAGES, capped at 32),
// rounding, two product stages, and sum with saturation into the output
// register. The whole pipe advances together when the output stage is
// empty or being taken, so a stall holds every item in place.
module euler_to_quaternion #(
    parameter int ANGLE_WIDTH = e2q_pkg::ANGLE_WIDTH_DEF,
    parameter int TRIG_STAGES = e2q_pkg::TRIG_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // roll_angle [ANGLE_WIDTH-1:0], pitch_angle, yaw_angle, zero fill
    input  logic [((3*ANGLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]
    output logic [63:0] m_axis_tdata
);
    import e2q_pkg::*;

    localparam int NS  = (TRIG_STAGES < MAX_STAGES) ? TRIG_STAGES : MAX_STAGES;
    localparam int LAT = NS + 6;

    logic           w_en;
    logic [LAT-1:0] r_vld;

    // pipeline moves when the last stage is empty or drained
    assign w_en          = !r_vld[LAT-1] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    logic signed [17:0] w_cr, w_sr, w_cp, w_sp, w_cy, w_sy;

    e2q_trig #(.ANGLE_WIDTH(ANGLE_WIDTH), .TRIG_STAGES(TRIG_STAGES)) u_roll (
        .i_clk(i_clk), .i_en(w_en),
        .i_angle(s_axis_tdata[ANGLE_WIDTH-1:0]), .o_cos(w_cr), .o_sin(w_sr));
    e2q_trig #(.ANGLE_WIDTH(ANGLE_WIDTH), .TRIG_STAGES(TRIG_STAGES)) u_pitch (
        .i_clk(i_clk), .i_en(w_en),
        .i_angle(s_axis_tdata[2*ANGLE_WIDTH-1:ANGLE_WIDTH]),
        .o_cos(w_cp), .o_sin(w_sp));
    e2q_trig #(.ANGLE_WIDTH(ANGLE_WIDTH), .TRIG_STAGES(TRIG_STAGES)) u_yaw (
        .i_clk(i_clk), .i_en(w_en),
        .i_angle(s_axis_tdata[3*ANGLE_WIDTH-1:2*ANGLE_WIDTH]),
        .o_cos(w_cy), .o_sin(w_sy));

    // roll by pitch products, yaw delayed to match
    logic signed [35:0] r_cc, r_ss, r_sc, r_cs;
    logic signed [17:0] r_cy, r_sy;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cc <= w_cr * w_cp;
            r_ss <= w_sr * w_sp;
            r_sc <= w_sr * w_cp;
            r_cs <= w_cr * w_sp;
            r_cy <= w_cy;
            r_sy <= w_sy;
        end
    end

    // eight triple products in q48
    logic signed [53:0] r_t [8];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t[0] <= r_cc * r_cy;  r_t[1] <= r_ss * r_sy;
            r_t[2] <= r_sc * r_cy;  r_t[3] <= r_cs * r_sy;
            r_t[4] <= r_cs * r_cy;  r_t[5] <= r_sc * r_sy;
            r_t[6] <= r_cc * r_sy;  r_t[7] <= r_ss * r_cy;
        end
    end

    function automatic logic [15:0] to_q14(input logic signed [54:0] v);
        logic signed [54:0] r;
        begin
            r = (v + (55'sd1 <<< 33)) >>> 34;
            if (r > 55'(Q14_ONE))       to_q14 = 16'(Q14_ONE);
            else if (r < -55'(Q14_ONE)) to_q14 = 16'(-Q14_ONE);
            else                        to_q14 = r[15:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            m_axis_tdata[15:0]  <= to_q14(55'(r_t[0]) + 55'(r_t[1]));
            m_axis_tdata[31:16] <= to_q14(55'(r_t[2]) - 55'(r_t[3]));
            m_axis_tdata[47:32] <= to_q14(55'(r_t[4]) + 55'(r_t[5]));
            m_axis_tdata[63:48] <= to_q14(55'(r_t[6]) - 55'(r_t[7]));
        end
    end

endmodule

/* verif/e2q_checker.sv */
// e2q_checker: watches both stream channels of euler_to_quaternion, predicts each quaternion
// depends on e2q_pkg for the cordic constants and the arctangent table
`timescale 1ns / 100ps

module e2q_checker #(
    parameter int ANGLE_WIDTH = 16,
    parameter int TRIG_STAGES = 16,
    parameter int DW = ((3*ANGLE_WIDTH+7)/8)*8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  logic [DW-1:0] i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  logic [63:0]   i_out_data,
    output int            o_fail_count,
    output int            o_pending,
    output int            o_seen
);
    import e2q_pkg::*;

    logic [63:0] quat_fifo[$];

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    // half angle cosine and sine, each in Q16
    function automatic void half_cos_sin(logic [ANGLE_WIDTH-1:0] raw,
                                         output longint c16, output longint s16);
        longint a, x, y, z, dx, dy, c, s;
        logic [63:0] prod;
        logic [31:0] phase, r;
        logic [1:0] quad;
        a = longint'(signed'(raw));
        prod = 64'(a) * 64'(PHASE_MUL);
        phase = prod[47:16];
        quad = 2'((phase + 32'h2000_0000) >> 30);
        r = phase - (32'(quad) << 30);
        z = longint'(signed'(r));
        x = longint'(CORDIC_X0);
        y = 0;
        for (int i = 0; i < TRIG_STAGES && i < MAX_STAGES; i++) begin
            dx = asr(y, i);
            dy = asr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_lookup(i));
            end else begin
                x += dx; y -= dy; z += longint'(atan_lookup(i));
            end
        end
        case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        c16 = asr(c + 8192, 14);
        s16 = asr(s + 8192, 14);
    endfunction

    function automatic logic [15:0] round_sat_q14(longint v48);
        longint v;
        v = asr(v48 + (longint'(1) << 33), 34);
        if (v > 16384) v = 16384;
        if (v < -16384) v = -16384;
        return v[15:0];
    endfunction

    function automatic logic [63:0] quaternion_of(logic [DW-1:0] d);
        longint cr, sr, cp, sp, cy, sy;
        half_cos_sin(d[ANGLE_WIDTH-1:0], cr, sr);
        half_cos_sin(d[2*ANGLE_WIDTH-1:ANGLE_WIDTH], cp, sp);
        half_cos_sin(d[3*ANGLE_WIDTH-1:2*ANGLE_WIDTH], cy, sy);
        return {round_sat_q14(cr*cp*sy - sr*sp*cy),
                round_sat_q14(cr*sp*cy + sr*cp*sy),
                round_sat_q14(sr*cp*cy - cr*sp*sy),
                round_sat_q14(cr*cp*cy + sr*sp*sy)};
    endfunction

    initial begin
        o_fail_count = 0;
        o_seen = 0;
    end
    assign o_pending = quat_fifo.size();

    always @(posedge i_clk) begin
        logic [63:0] want;
        if (i_rst_n && i_in_valid && i_in_ready)
            quat_fifo.push_back(quaternion_of(i_in_data));
        if (i_rst_n && i_out_valid && i_out_ready) begin
            o_seen <= o_seen + 1;
            if (quat_fifo.size() == 0) begin
                if (o_fail_count < 10)
                    $display("unexpected result %h", i_out_data);
                o_fail_count <= o_fail_count + 1;
            end else begin
                want = quat_fifo.pop_front();
                if (want !== i_out_data) begin
                    if (o_fail_count < 10)
                        $display("mismatch w/x/y/z exp %h %h %h %h got %h %h %h %h",
                                 want[15:0], want[31:16], want[47:32], want[63:48],
                                 i_out_data[15:0], i_out_data[31:16],
                                 i_out_data[47:32], i_out_data[63:48]);
                    o_fail_count <= o_fail_count + 1;
                end
            end
        end
    end
endmodule

/* verif/euler_to_quaternion_tb.sv */
// euler_to_quaternion_tb: stimulus and verdict for the euler angle to quaternion pipeline
// depends on euler_to_quaternion, e2q_pkg and e2q_checker
`timescale 1ns / 100ps

module euler_to_quaternion_tb;
    localparam int AW = 16;
    localparam int DW = ((3*AW+7)/8)*8;
    localparam int LIMIT = 400000;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_valid;
    logic          s_ready;
    // roll [15:0], pitch [31:16], yaw [47:32]
    logic [DW-1:0] s_data;
    logic          m_valid;
    logic          m_ready;
    // quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]
    logic [63:0]   m_data;
    int            fail_count, pending, seen;
    int            send_idle, recv_idle;  // idle percentages
    bit            hold_off;              // long receiver stall
    int            cycles;

    euler_to_quaternion u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data)
    );

    e2q_checker #(.ANGLE_WIDTH(AW), .TRIG_STAGES(16)) u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_valid), .i_in_ready(s_ready), .i_in_data(s_data),
        .i_out_valid(m_valid), .i_out_ready(m_ready), .i_out_data(m_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_seen(seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // cycle limit watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("FAIL euler_to_quaternion");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_ready <= !hold_off && ($urandom_range(99) >= recv_idle);
        end
    end

    // one transaction, idling at random before the offer
    task automatic send_angles(logic [AW-1:0] roll, logic [AW-1:0] pitch, logic [AW-1:0] yaw);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= {{(DW-3*AW){1'b0}}, yaw, pitch, roll};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [AW-1:0] rand_angle();
        case ($urandom_range(3))
            0: return AW'($urandom);
            1: return AW'($urandom_range(12868) - 6434);   // within about pi/2
            2: return AW'($urandom_range(51471) - 25735);  // about plus or minus 2 pi
            default: return AW'($urandom_range(1) ? 16'h7fff - $urandom_range(7)
                                                  : 16'h8000 + $urandom_range(7));
        endcase
    endfunction

    // edge angles: zero, extremes, quarter and half turns, multiples of pi
    logic [AW-1:0] corner[12] = '{16'sd0, 16'sd32767, 16'sh8000, 16'sd1, -16'sd1,
                                  16'sd6434, -16'sd6434, 16'sd12868, -16'sd12868,
                                  16'sd25736, 16'sd19302, 16'sh5555};

    initial begin
        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        hold_off = 1'b0;
        send_idle = 13;
        recv_idle = 75;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: each corner on one axis in turn, then all axes together
        for (int k = 0; k < 12; k++) begin
            case (k % 3)
                0: send_angles(corner[k], 16'd0, 16'd0);
                1: send_angles(16'd0, corner[k], 16'd0);
                default: send_angles(16'd0, 16'd0, corner[k]);
            endcase
        end
        for (int k = 0; k < 12; k++)
            send_angles(corner[k], corner[(k+4)%12], corner[(k+8)%12]);

        // long receiver hold-off while the sender keeps offering
        fork
            begin
                @(negedge i_clk);
                hold_off = 1'b1;
                repeat (120) @(negedge i_clk);
                hold_off = 1'b0;
            end
            for (int n = 0; n < 60; n++) send_angles(rand_angle(), rand_angle(), rand_angle());
        join

        for (int phase_i = 0; phase_i < 3; phase_i++) begin
            send_idle = (phase_i == 0) ? 13 : (phase_i == 1) ? 75 : 0;
            recv_idle = (phase_i == 0) ? 75 : (phase_i == 1) ? 13 : 0;
            for (int n = 0; n < 210; n++) begin
                // stretches without idling inside each phase
                if (n == 150) begin
                    send_idle = 0;
                    recv_idle = 0;
                end
                send_angles(rand_angle(), rand_angle(), rand_angle());
            end
        end
        s_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("covered %0d quaternions: corner angles per axis, full-range and wrapped angles,",
                 seen);
        $display("random idling on both sides and a long output stall");
        if (fail_count == 0) begin
            $display("PASS euler_to_quaternion");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("FAIL euler_to_quaternion");
        end
        $finish;
    end
endmodule
